/* sv/ttcc_pkg.sv */
package ttcc_pkg;

  // Result commands as they appear on the result channel.
  typedef enum logic [2:0] {
    CMD_UL_OFF   = 3'd0,
    CMD_UL_ON    = 3'd1,
    CMD_GLYPH    = 3'd2,
    CMD_SCROLL   = 3'd3,
    CMD_CLEAR    = 3'd4,
    CMD_KEY      = 3'd5,
    CMD_EMPTY    = 3'd6,
    CMD_OVERFLOW = 3'd7
  } cmd_t;

  // Operation codes of an input item.
  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_KEY_IN = 2'd1,
    OP_READ   = 2'd2,
    OP_TICK   = 2'd3
  } op_t;

  // Work handed from the front end to the back end.
  typedef enum logic [2:0] {
    JOB_WRITE    = 3'd0,
    JOB_TICK     = 3'd1,
    JOB_KEY      = 3'd2,
    JOB_EMPTY    = 3'd3,
    JOB_OVERFLOW = 3'd4
  } job_kind_t;

  typedef struct packed {
    job_kind_t  kind;
    logic [7:0] data;
  } job_t;

  // Configuration registers as one group.
  typedef struct packed {
    logic       echo;
    logic [7:0] columns;
    logic [6:0] rows;
    logic [7:0] period;
  } cfg_t;

  typedef enum logic [1:0] {
    CFG_ECHO    = 2'd0,
    CFG_COLUMNS = 2'd1,
    CFG_ROWS    = 2'd2,
    CFG_PERIOD  = 2'd3
  } cfg_index_t;

  // Back end sequencer states.
  typedef enum logic {
    BK_RUN    = 1'b0,
    BK_REDUCE = 1'b1
  } bk_state_t;

  localparam logic [7:0] CHAR_BS    = 8'h08;
  localparam logic [7:0] CHAR_NL    = 8'h0A;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  localparam logic [7:0] COLUMNS_RESET = 8'd80;
  localparam logic [6:0] ROWS_RESET    = 7'd25;
  localparam logic [7:0] PERIOD_RESET  = 8'd75;

  localparam int QUEUE_DEPTH = 4;

endpackage

/* sv/ttcc_ram.sv */
module ttcc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // One write port, one registered read port; read data holds between reads.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

/* sv/ttcc_front.sv */
module ttcc_front #(
  parameter int KEY_DEPTH = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [1:0]    in_operation,
  input  logic [7:0]    in_char_code,
  input  logic          echo_enable,
  input  logic          q_full,
  output logic          q_push,
  output ttcc_pkg::job_t q_job
);
  import ttcc_pkg::*;

  localparam int AW = $clog2(KEY_DEPTH);
  localparam logic [AW-1:0] LAST_ADDR = AW'(KEY_DEPTH - 1);

  logic [AW-1:0] wp_r, wp_nxt, rp_r, rp_nxt, wp_inc, rp_inc;
  logic          ring_full, ring_empty;
  logic          accept, job_need, wp_adv, rp_adv;
  job_t          job_new;
  logic          stage_valid_r, stage_valid_nxt;
  job_t          stage_job_r;
  logic [7:0]    ram_rdata;

  // Ring pointers wrap at the configured depth.
  assign wp_inc     = (wp_r == LAST_ADDR) ? '0 : wp_r + 1'b1;
  assign rp_inc     = (rp_r == LAST_ADDR) ? '0 : rp_r + 1'b1;
  assign ring_full  = (wp_inc == rp_r);
  assign ring_empty = (wp_r == rp_r);

  // The stage holds one classified item until the queue takes it.
  assign in_stall = stage_valid_r && q_full;
  assign accept   = in_valid && !in_stall;
  assign q_push   = stage_valid_r && !q_full;

  // Classify the item and decide what the key ring does with it.
  always_comb begin
    job_new.kind = JOB_WRITE;
    job_new.data = in_char_code;
    job_need     = 1'b0;
    wp_adv       = 1'b0;
    rp_adv       = 1'b0;
    case (op_t'(in_operation))
      OP_WRITE: begin
        job_need = 1'b1;
      end
      OP_KEY_IN: begin
        if (ring_full) begin
          job_new.kind = JOB_OVERFLOW;
          job_need     = 1'b1;
        end else begin
          wp_adv   = 1'b1;
          job_need = echo_enable;
        end
      end
      OP_READ: begin
        job_need = 1'b1;
        if (ring_empty) begin
          job_new.kind = JOB_EMPTY;
        end else begin
          job_new.kind = JOB_KEY;
          rp_adv       = 1'b1;
        end
      end
      OP_TICK: begin
        job_new.kind = JOB_TICK;
        job_need     = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign wp_nxt = (accept && wp_adv) ? wp_inc : wp_r;
  assign rp_nxt = (accept && rp_adv) ? rp_inc : rp_r;

  always_comb begin
    if (accept) begin
      stage_valid_nxt = job_need;
    end else if (q_push) begin
      stage_valid_nxt = 1'b0;
    end else begin
      stage_valid_nxt = stage_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r          <= '0;
      rp_r          <= '0;
      stage_valid_r <= 1'b0;
    end else begin
      wp_r          <= wp_nxt;
      rp_r          <= rp_nxt;
      stage_valid_r <= stage_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage_job_r <= job_new;
    end
  end

  // Key ring storage; the read data arrives with the staged item.
  ttcc_ram #(
    .WIDTH (8),
    .DEPTH (KEY_DEPTH)
  ) u_key_ram (
    .clk     (clk),
    .wr_en   (accept && wp_adv),
    .wr_addr (wp_r),
    .wr_data (in_char_code),
    .rd_en   (accept && rp_adv),
    .rd_addr (rp_r),
    .rd_data (ram_rdata)
  );

  always_comb begin
    q_job.kind = stage_job_r.kind;
    q_job.data = (stage_job_r.kind == JOB_KEY) ? ram_rdata : stage_job_r.data;
  end

endmodule

/* sv/ttcc_queue.sv */
module ttcc_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  ttcc_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output ttcc_pkg::job_t pop_job,
  output logic           empty
);
  import ttcc_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PW-1:0] LAST_SLOT = PW'(QUEUE_DEPTH - 1);

  job_t          mem_r [QUEUE_DEPTH];
  logic [PW-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full    = (count_r == CW'(QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign pop_job = mem_r[head_r];

  // Pointer and fill count update.
  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    if (push) begin
      tail_nxt = (tail_r == LAST_SLOT) ? '0 : tail_r + 1'b1;
    end
    if (pop) begin
      head_nxt = (head_r == LAST_SLOT) ? '0 : head_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[tail_r] <= push_job;
    end
  end

endmodule

/* sv/ttcc_back.sv */
module ttcc_back (
  input  logic           clk,
  input  logic           rst_n,
  input  ttcc_pkg::cfg_t cfg,
  input  logic           q_empty,
  input  ttcc_pkg::job_t q_job,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [2:0]     out_command,
  output logic [7:0]     out_cell_column,
  output logic [6:0]     out_cell_row,
  output logic [7:0]     out_glyph_code,
  output logic [7:0]     out_key_byte,
  output logic           out_last
);
  import ttcc_pkg::*;

  // Result slots of one job, emitted lowest bit first.
  localparam int PL_ULOLD  = 0;
  localparam int PL_ULLEFT = 1;
  localparam int PL_SCROLL = 2;
  localparam int PL_CLEAR  = 3;
  localparam int PL_GLYPH  = 4;
  localparam int PL_SINGLE = 5;
  localparam int PL_N      = 6;
  localparam int RED_STEPS = 9;

  // Cursor and blink state.
  logic [7:0] cur_col_r, jb_col;
  logic [6:0] cur_row_r, jb_row;
  logic [7:0] blink_cnt_r, blink_cnt_nxt, jb_cnt;
  logic       blink_on_r, jb_on;

  // Plan of the job in progress.
  logic [PL_N-1:0] plan_r, plan_nxt, np_plan, sel, remain;
  logic [7:0] pl_col_r, pl_gcol_r, pl_gchar_r, pl_key_r;
  logic [6:0] pl_row_r, pl_nrow_r, pl_grow_r;
  cmd_t       pl_scmd_r;
  logic [7:0] np_col, np_gcol, np_gchar, np_key;
  logic [6:0] np_row, np_nrow, np_grow;
  cmd_t       np_scmd;

  // Remainder unit for a blink count above the period.
  bk_state_t  state_r, state_nxt;
  logic [8:0] red_div_r, red_seed, red_t, red_sub;
  logic [7:0] red_rem_r;
  logic [3:0] red_step_r;
  logic       red_start, red_active, red_done;

  // Output register.
  logic       out_valid_r, out_valid_nxt, load_ok, emit;
  cmd_t       out_cmd_r, o_cmd;
  logic [7:0] out_col_r, out_glyph_r, out_key_r, o_col, o_glyph, o_key;
  logic [6:0] out_row_r, o_row;
  logic       out_last_r;

  assign load_ok = !out_valid_r || !out_stall;
  assign emit    = (plan_r != '0) && load_ok;
  assign sel     = plan_r & (~plan_r + 1'b1);
  assign remain  = plan_r & ~sel;
  assign q_pop   = (state_r == BK_RUN) && !q_empty &&
                   ((plan_r == '0) || (emit && (remain == '0)));

  // Decode the job at the head of the queue against the current cursor.
  always_comb begin
    logic       col_vis, left_vis, bump;
    logic [6:0] bottom_row, nl_row;
    logic [8:0] cnt_inc;
    col_vis    = cur_col_r < cfg.columns;
    left_vis   = (cur_col_r - 8'd1) < cfg.columns;
    bump       = ({1'b0, cur_row_r} + 8'd1) >= {1'b0, cfg.rows};
    bottom_row = (cfg.rows != 7'd0) ? cfg.rows - 7'd1 : 7'd0;
    nl_row     = bump ? bottom_row : cur_row_r + 7'd1;
    cnt_inc    = {1'b0, blink_cnt_r} + 9'd1;

    np_plan   = '0;
    np_col    = cur_col_r;
    np_row    = cur_row_r;
    np_nrow   = nl_row;
    np_gcol   = cur_col_r;
    np_grow   = cur_row_r;
    np_gchar  = q_job.data;
    np_scmd   = CMD_EMPTY;
    np_key    = '0;
    jb_col    = cur_col_r;
    jb_row    = cur_row_r;
    jb_cnt    = blink_cnt_r;
    jb_on     = blink_on_r;
    red_start = 1'b0;
    red_seed  = cnt_inc;

    case (q_job.kind)
      JOB_WRITE: begin
        if (q_job.data == CHAR_BS) begin
          // Backspace at column zero does nothing.
          if (cur_col_r != 8'd0) begin
            np_plan[PL_ULOLD]  = col_vis;
            np_plan[PL_ULLEFT] = left_vis;
            np_plan[PL_GLYPH]  = 1'b1;
            np_gcol            = cur_col_r - 8'd1;
            np_gchar           = CHAR_SPACE;
            jb_col             = cur_col_r - 8'd1;
            jb_cnt             = '0;
            jb_on              = 1'b0;
          end
        end else if (q_job.data == CHAR_NL) begin
          np_plan[PL_ULOLD]  = col_vis;
          np_plan[PL_SCROLL] = bump;
          np_plan[PL_CLEAR]  = bump;
          jb_col             = '0;
          jb_row             = nl_row;
          jb_cnt             = '0;
          jb_on              = 1'b0;
        end else begin
          np_plan[PL_ULOLD] = col_vis;
          np_plan[PL_GLYPH] = 1'b1;
          if (!col_vis) begin
            // Past the last column: wrap first, then draw.
            np_plan[PL_SCROLL] = bump;
            np_plan[PL_CLEAR]  = bump;
            np_gcol            = '0;
            np_grow            = nl_row;
            jb_col             = 8'd1;
            jb_row             = nl_row;
          end else begin
            jb_col = cur_col_r + 8'd1;
          end
          jb_cnt = '0;
          jb_on  = 1'b0;
        end
      end
      JOB_TICK: begin
        if (blink_cnt_r == 8'd0) begin
          jb_on              = !blink_on_r;
          np_plan[PL_SINGLE] = 1'b1;
          np_scmd            = !blink_on_r ? CMD_UL_ON : CMD_UL_OFF;
        end
        if (cfg.period == 8'd0) begin
          jb_cnt = cnt_inc[7:0];
        end else if (cnt_inc < {1'b0, cfg.period}) begin
          jb_cnt = cnt_inc[7:0];
        end else if (cnt_inc == {1'b0, cfg.period}) begin
          jb_cnt = '0;
        end else begin
          red_start = 1'b1;
        end
      end
      JOB_KEY: begin
        np_plan[PL_SINGLE] = 1'b1;
        np_scmd            = CMD_KEY;
        np_key             = q_job.data;
        np_col             = '0;
        np_row             = '0;
      end
      JOB_EMPTY: begin
        np_plan[PL_SINGLE] = 1'b1;
        np_scmd            = CMD_EMPTY;
        np_col             = '0;
        np_row             = '0;
      end
      JOB_OVERFLOW: begin
        np_plan[PL_SINGLE] = 1'b1;
        np_scmd            = CMD_OVERFLOW;
        np_key             = q_job.data;
        np_col             = '0;
        np_row             = '0;
      end
      default: begin
      end
    endcase
  end

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_RUN: begin
        if (q_pop && red_start) begin
          state_nxt = BK_REDUCE;
        end
      end
      BK_REDUCE: begin
        if (red_step_r == 4'd0) begin
          state_nxt = BK_RUN;
        end
      end
      default: begin
        state_nxt = BK_RUN;
      end
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    red_active = 1'b0;
    red_done   = 1'b0;
    case (state_r)
      BK_REDUCE: begin
        red_active = 1'b1;
        red_done   = (red_step_r == 4'd0);
      end
      default: begin
      end
    endcase
  end

  // One restoring remainder step per cycle.
  assign red_t   = {red_rem_r, red_div_r[8]};
  assign red_sub = (red_t >= {1'b0, cfg.period}) ? red_t - {1'b0, cfg.period} : red_t;

  always_comb begin
    if (q_pop) begin
      blink_cnt_nxt = jb_cnt;
    end else if (red_done) begin
      blink_cnt_nxt = red_sub[7:0];
    end else begin
      blink_cnt_nxt = blink_cnt_r;
    end
  end

  always_comb begin
    if (q_pop) begin
      plan_nxt = np_plan;
    end else if (emit) begin
      plan_nxt = remain;
    end else begin
      plan_nxt = plan_r;
    end
  end

  // Pick the fields of the next result from the plan.
  always_comb begin
    o_cmd   = pl_scmd_r;
    o_col   = '0;
    o_row   = '0;
    o_glyph = '0;
    o_key   = '0;
    if (sel[PL_ULOLD]) begin
      o_cmd = CMD_UL_OFF;
      o_col = pl_col_r;
      o_row = pl_row_r;
    end else if (sel[PL_ULLEFT]) begin
      o_cmd = CMD_UL_OFF;
      o_col = pl_gcol_r;
      o_row = pl_grow_r;
    end else if (sel[PL_SCROLL]) begin
      o_cmd = CMD_SCROLL;
    end else if (sel[PL_CLEAR]) begin
      o_cmd = CMD_CLEAR;
      o_row = pl_nrow_r;
    end else if (sel[PL_GLYPH]) begin
      o_cmd   = CMD_GLYPH;
      o_col   = pl_gcol_r;
      o_row   = pl_grow_r;
      o_glyph = pl_gchar_r;
    end else begin
      o_col = pl_col_r;
      o_row = pl_row_r;
      o_key = pl_key_r;
    end
  end

  always_comb begin
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_RUN;
      plan_r      <= '0;
      out_valid_r <= 1'b0;
      cur_col_r   <= '0;
      cur_row_r   <= '0;
      blink_cnt_r <= '0;
      blink_on_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      plan_r      <= plan_nxt;
      out_valid_r <= out_valid_nxt;
      blink_cnt_r <= blink_cnt_nxt;
      if (q_pop) begin
        cur_col_r  <= jb_col;
        cur_row_r  <= jb_row;
        blink_on_r <= jb_on;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      pl_col_r   <= np_col;
      pl_row_r   <= np_row;
      pl_nrow_r  <= np_nrow;
      pl_gcol_r  <= np_gcol;
      pl_grow_r  <= np_grow;
      pl_gchar_r <= np_gchar;
      pl_scmd_r  <= np_scmd;
      pl_key_r   <= np_key;
    end
    if (q_pop && red_start) begin
      red_div_r  <= red_seed;
      red_rem_r  <= '0;
      red_step_r <= 4'(RED_STEPS - 1);
    end else if (red_active) begin
      red_div_r  <= {red_div_r[7:0], 1'b0};
      red_rem_r  <= red_sub[7:0];
      red_step_r <= red_step_r - 4'd1;
    end
    if (emit) begin
      out_cmd_r   <= o_cmd;
      out_col_r   <= o_col;
      out_row_r   <= o_row;
      out_glyph_r <= o_glyph;
      out_key_r   <= o_key;
      out_last_r  <= (remain == '0);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_command     = out_cmd_r;
  assign out_cell_column = out_col_r;
  assign out_cell_row    = out_row_r;
  assign out_glyph_code  = out_glyph_r;
  assign out_key_byte    = out_key_r;
  assign out_last        = out_last_r;

endmodule

/* sv/text_terminal_cursor_controller.sv */
// Text terminal cursor controller.
// Input channel (in_valid/in_stall): one operation per item, write character,
// key arrived, read one key, or blink tick, with its character byte.
// Result channel (out_valid/out_stall): drawing commands and read answers, one
// per cycle while out_stall is low; out_last marks the final result of an item.
// Some items (a key stored without echo, backspace at column zero, most ticks)
// give no result. The user must write configuration (cfg_we/cfg_index/
// cfg_wdata) only while the block idles; the block itself does not enforce
// it. The first result of an item passes the input stage, job queue, plan
// register and output register. Throughput: an item enters every cycle while
// the four-entry job queue has room; the back end emits one result per cycle
// while out_stall is low. A tick whose blink count lies above a newly lowered
// period holds the back end in the bit-serial remainder unit. Reset clears the
// cursor, blink state, key ring pointers and queues and sets the registers to
// their defaults. A stalled receiver holds the output register; the queue
// fills, and then in_stall rises to hold the input.
module text_terminal_cursor_controller #(
  parameter int KEY_DEPTH = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_operation,
  input  logic [7:0] in_char_code,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_command,
  output logic [7:0] out_cell_column,
  output logic [6:0] out_cell_row,
  output logic [7:0] out_glyph_code,
  output logic [7:0] out_key_byte,
  output logic       out_last,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_wdata
);
  import ttcc_pkg::*;

  cfg_t cfg_r;
  logic q_push, q_pop, q_full, q_empty;
  job_t push_job, pop_job;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.echo    <= 1'b0;
      cfg_r.columns <= COLUMNS_RESET;
      cfg_r.rows    <= ROWS_RESET;
      cfg_r.period  <= PERIOD_RESET;
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_ECHO:    cfg_r.echo    <= cfg_wdata[0];
        CFG_COLUMNS: cfg_r.columns <= cfg_wdata;
        CFG_ROWS:    cfg_r.rows    <= cfg_wdata[6:0];
        CFG_PERIOD:  cfg_r.period  <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  ttcc_front #(
    .KEY_DEPTH (KEY_DEPTH)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_operation (in_operation),
    .in_char_code (in_char_code),
    .echo_enable  (cfg_r.echo),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_job        (push_job)
  );

  ttcc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .pop_job  (pop_job),
    .empty    (q_empty)
  );

  ttcc_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .q_empty         (q_empty),
    .q_job           (pop_job),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_command     (out_command),
    .out_cell_column (out_cell_column),
    .out_cell_row    (out_cell_row),
    .out_glyph_code  (out_glyph_code),
    .out_key_byte    (out_key_byte),
    .out_last        (out_last)
  );

endmodule

/* sv/ttcc_checker.sv */
module ttcc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [2:0] out_command,
  input logic [7:0] out_cell_column,
  input logic [6:0] out_cell_row,
  input logic [7:0] out_glyph_code,
  input logic [7:0] out_key_byte,
  input logic       out_last
);
  import ttcc_pkg::*;

  // Reset empties the output register and the input stage.
  a_reset_clear: assert property (@(posedge clk) !rst_n |=> !out_valid && !in_stall)
    else $error("output or input stall active after reset");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_command) &&
      $stable(out_cell_column) && $stable(out_cell_row) &&
      $stable(out_glyph_code) && $stable(out_key_byte) && $stable(out_last))
    else $error("stalled result changed");

  // A taken scroll is followed at once by the clear of the bottom line.
  a_scroll_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && (out_command == CMD_SCROLL) |=>
      out_valid && (out_command == CMD_CLEAR))
    else $error("scroll not followed by clear bottom");

  // Read answers and underline on stand alone in their item.
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((out_command == CMD_KEY) || (out_command == CMD_EMPTY) ||
      (out_command == CMD_OVERFLOW) || (out_command == CMD_UL_ON)) |-> out_last)
    else $error("single result without last");

endmodule

bind text_terminal_cursor_controller ttcc_checker u_ttcc_checker (.*);
